// ===== rtl/rotation_matrix_to_quaternion_macros.svh =====
// Assertion macros used by the rotation matrix to quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define RMQ_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rmq assertion failed");
// cond implies expr at the same clock edge outside reset
`define RMQ_ASSERT_IMP(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rmq implication failed");
`else
`define RMQ_ASSERT(lbl, clk, rst, expr)
`define RMQ_ASSERT_IMP(lbl, clk, rst, cond, expr)
`endif
`endif

// ===== rtl/rmq_pkg.sv =====
// Types, constants and per-stage datapath functions for the quaternion pipeline.
package rmq_pkg;

   localparam logic [14:0] QONE_MAG = 15'd16384;

   // dominant component codes; AXIS_W is the positive-trace case
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam logic [1:0] AXIS_W = 2'd3;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic               invalid;
   } rsp_type;

   typedef struct packed {
      logic              invalid;
      logic [1:0]        axis;
      logic [31:0]       sq_num;   // A << 14, consumed four bits a stage
      logic [18:0]       sq_rem;
      logic [15:0]       sq_res;   // becomes S
      logic [2:0][16:0]  d;        // signed off-diagonal sums/differences
      logic [2:0]        neg;
      logic [2:0][29:0]  num;      // |d| * 8192 + S/2
      logic [2:0][16:0]  rem;
      logic [2:0][14:0]  quo;
      logic [2:0]        ovf;      // quotient >= 2^15
   } pipe_type;

   // two digits of the square root
   function automatic pipe_type sq_step(pipe_type p, int t_hi);
      pipe_type    r;
      logic [18:0] rem;
      logic [18:0] trial;
      r = p;
      for (int n = 0; n < 2; n++) begin
         rem   = {r.sq_rem[16:0], r.sq_num[2*(t_hi-n) +: 2]};
         trial = {1'b0, r.sq_res, 2'b01};
         if (rem >= trial) begin
            r.sq_rem = rem - trial;
            r.sq_res = {r.sq_res[14:0], 1'b1};
         end else begin
            r.sq_rem = rem;
            r.sq_res = {r.sq_res[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   // dividend with rounding bias, overflow check, first partial remainder
   function automatic pipe_type div_prep(pipe_type p);
      pipe_type    r;
      logic [16:0] mag;
      r = p;
      for (int l = 0; l < 3; l++) begin
         r.neg[l] = p.d[l][16];
         mag      = p.d[l][16] ? 17'(-p.d[l]) : p.d[l];
         r.num[l] = {mag, 13'b0} + 30'(p.sq_res[15:1]);
         r.ovf[l] = {1'b0, r.num[l]} >= {p.sq_res, 15'b0};
         r.rem[l] = {2'b00, r.num[l][29:15]};
         r.quo[l] = '0;
      end
      return r;
   endfunction

   // three quotient bits on each of the three lanes
   function automatic pipe_type div_step(pipe_type p, int t_hi);
      pipe_type    r;
      logic [16:0] rem;
      r = p;
      for (int l = 0; l < 3; l++) begin
         for (int n = 0; n < 3; n++) begin
            rem = {r.rem[l][15:0], r.num[l][t_hi-n]};
            if (rem >= {1'b0, p.sq_res}) begin
               r.rem[l]          = rem - {1'b0, p.sq_res};
               r.quo[l][t_hi-n] = 1'b1;
            end else begin
               r.rem[l]          = rem;
               r.quo[l][t_hi-n] = 1'b0;
            end
         end
      end
      return r;
   endfunction

   // saturate, sign and route components to w, x, y, z; zero them when invalid
   function automatic rsp_type to_rsp(pipe_type p);
      rsp_type          o;
      logic [14:0]      dmag;
      logic [14:0]      m;
      logic [2:0][15:0] v;
      logic [15:0]      dom;
      dmag = ({1'b0, p.sq_res[15:1]} > {1'b0, QONE_MAG}) ? QONE_MAG : p.sq_res[15:1];
      dom  = {1'b0, dmag};
      for (int l = 0; l < 3; l++) begin
         m    = (p.ovf[l] || (p.quo[l] > QONE_MAG)) ? QONE_MAG : p.quo[l];
         v[l] = p.neg[l] ? 16'(-{1'b0, m}) : {1'b0, m};
      end
      o.invalid = p.invalid;
      unique case (p.axis)
         AXIS_W: begin
            o.quat_w = dom;  o.quat_x = v[0]; o.quat_y = v[1]; o.quat_z = v[2];
         end
         AXIS_X: begin
            o.quat_x = dom;  o.quat_y = v[0]; o.quat_z = v[1]; o.quat_w = v[2];
         end
         AXIS_Y: begin
            o.quat_y = dom;  o.quat_z = v[0]; o.quat_x = v[1]; o.quat_w = v[2];
         end
         default: begin
            o.quat_z = dom;  o.quat_x = v[0]; o.quat_y = v[1]; o.quat_w = v[2];
         end
      endcase
      if (p.invalid) begin
         o.quat_w = '0; o.quat_x = '0; o.quat_y = '0; o.quat_z = '0;
      end
      return o;
   endfunction

endpackage

// ===== rtl/rmq_front.sv =====
// Front end: branch and axis choice, square-root argument, off-diagonal terms.
module rmq_front (
   input  rmq_pkg::req_type  req,
   output rmq_pkg::pipe_type pipe
);
   import rmq_pkg::*;

   logic signed [18:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [18:0] tr;
   logic signed [18:0] a;
   logic               trace_br;
   logic [1:0]         ax;
   logic signed [18:0] dd0, dd1, dd2;

   assign e00 = 19'(req.m00);
   assign e01 = 19'(req.m01);
   assign e02 = 19'(req.m02);
   assign e10 = 19'(req.m10);
   assign e11 = 19'(req.m11);
   assign e12 = 19'(req.m12);
   assign e20 = 19'(req.m20);
   assign e21 = 19'(req.m21);
   assign e22 = 19'(req.m22);

   assign tr       = e00 + e11 + e22;
   assign trace_br = tr > 19'sd0;

   // largest diagonal entry, lowest index on ties
   always_comb begin
      ax = AXIS_X;
      if (e11 > e00) ax = AXIS_Y;
      if ((ax == AXIS_X && e22 > e00) || (ax == AXIS_Y && e22 > e11)) ax = AXIS_Z;
   end

   // argument and the three quotient numerators per case
   always_comb begin
      a = '0; dd0 = '0; dd1 = '0; dd2 = '0;
      if (trace_br) begin
         a   = tr + 19'sd16384;
         dd0 = e21 - e12;
         dd1 = e02 - e20;
         dd2 = e10 - e01;
      end else begin
         unique case (ax)
            AXIS_X: begin
               a   = e00 - e11 - e22 + 19'sd16384;
               dd0 = e01 + e10; dd1 = e20 + e02; dd2 = e21 - e12;
            end
            AXIS_Y: begin
               a   = e11 - e22 - e00 + 19'sd16384;
               dd0 = e12 + e21; dd1 = e01 + e10; dd2 = e02 - e20;
            end
            default: begin
               a   = e22 - e00 - e11 + 19'sd16384;
               dd0 = e20 + e02; dd1 = e12 + e21; dd2 = e10 - e01;
            end
         endcase
      end
   end

   always_comb begin
      pipe         = '0;
      pipe.invalid = !trace_br && (a <= 19'sd0);
      pipe.axis    = trace_br ? AXIS_W : ax;
      pipe.sq_num  = pipe.invalid ? 32'd0 : {1'b0, a[16:0], 14'b0};
      pipe.d[0]    = dd0[16:0];
      pipe.d[1]    = dd1[16:0];
      pipe.d[2]    = dd2[16:0];
   end

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion (Shepperd's method), Q1.14, top level.
// Takes one matrix beat per cycle while req_stall is low and returns one
// quaternion beat per matrix. Each beat passes through the stage registers
// and then the result register behind rsp_valid. The rate is set by a fully
// pipelined square root (two result bits per stage, eight stages) followed by
// three parallel restoring dividers (three quotient bits per stage, five stages
// after a setup stage). Every stage carries its own valid bit and loads whenever
// the stage ahead can take its beat, so bubbles close up during a result stall
// and input keeps flowing until the pipe is full.
module rotation_matrix_to_quaternion (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmq_pkg::rsp_type  rsp_data
);
   import rmq_pkg::*;

   localparam int NP = 15;

   pipe_type front;
   pipe_type pipe_in  [NP];
   pipe_type pipe_ff  [NP];
   logic     vld_ff   [NP];
   logic     rdy      [NP+1];
   logic     rsp_vld_ff;
   rsp_type  rsp_ff;

   rmq_front u_front (
      .req  (req_data),
      .pipe (front)
   );

   // stage ready: empty, or the stage ahead takes the beat
   assign rdy[NP] = !rsp_vld_ff || !rsp_stall;
   for (genvar k = 0; k < NP; k++) begin : g_rdy
      assign rdy[k] = !vld_ff[k] || rdy[k+1];
   end
   assign req_stall = !rdy[0];

   // per-stage datapath
   for (genvar k = 0; k < NP; k++) begin : g_stage
      if (k == 0) begin : g_f
         assign pipe_in[k] = front;
      end else if (k <= 8) begin : g_sq
         assign pipe_in[k] = sq_step(pipe_ff[k-1], 15 - 2*(k-1));
      end else if (k == 9) begin : g_dp
         assign pipe_in[k] = div_prep(pipe_ff[k-1]);
      end else begin : g_dv
         assign pipe_in[k] = div_step(pipe_ff[k-1], 14 - 3*(k-10));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= (k == 0) ? req_valid : vld_ff[k == 0 ? 0 : k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rdy[NP]) begin
         rsp_vld_ff <= vld_ff[NP-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NP]) begin
         rsp_ff <= to_rsp(pipe_ff[NP-1]);
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`include "rotation_matrix_to_quaternion_macros.svh"

   // a valid argument always gives S of at least 128
   `RMQ_ASSERT_IMP(a_sqrt_min, clock, reset, vld_ff[8] && !pipe_ff[8].invalid, pipe_ff[8].sq_res >= 16'd128)
   // an invalid result carries all-zero components
   `RMQ_ASSERT_IMP(a_inv_zero, clock, reset, rsp_vld_ff && rsp_ff.invalid, rsp_ff.quat_w == 16'sd0 && rsp_ff.quat_x == 16'sd0 && rsp_ff.quat_y == 16'sd0 && rsp_ff.quat_z == 16'sd0)
   // only the non-trace case can be invalid
   `RMQ_ASSERT_IMP(a_inv_axis, clock, reset, vld_ff[0] && pipe_ff[0].invalid, pipe_ff[0].axis != AXIS_W)

endmodule
